FILE: hw/rtl/fqs_pkg.sv
// Shared types, codes and sizes for the searchable FIFO queue.
// Used by every module of the block; no dependencies of its own.
`timescale 1ns / 1ps

package fqs_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VAL_W   = 32;
  localparam int POS_W   = 5;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_LIST   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    status_t            status;
    logic [VAL_W-1:0]   item;
    logic [POS_W-1:0]   pos;
    logic               last;
  } res_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [VAL_W-1:0]   data;
  } ram_wr_t;

  // Circular slot of the entry at offset off behind the front.
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
                                              input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, front} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/fqs_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on fqs_pkg for the write request struct.
`timescale 1ns / 1ps

module fqs_ram #(
  parameter int WIDTH = 32,
  parameter int WORDS = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  fqs_pkg::ram_wr_t  wr,
  input  logic [AW-1:0]     rd_addr,
  output logic [WIDTH-1:0]  rd_data
);
  import fqs_pkg::*;

  logic [WIDTH-1:0] mem [WORDS];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[AW'(wr.addr)] <= WIDTH'(wr.data);
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/fqs_ctrl.sv
// Request sequencer: pointers, entry scan and the output result register.
// Depends on fqs_pkg; drives the entry RAM through a write struct and read address.
`timescale 1ns / 1ps

module fqs_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  fqs_pkg::req_t              in_req,
  input  logic [fqs_pkg::VAL_W-1:0]  in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output fqs_pkg::res_t              out_res,
  output fqs_pkg::ram_wr_t           ram_wr,
  output logic [fqs_pkg::IDX_W-1:0]  ram_rd_addr,
  input  logic [fqs_pkg::VAL_W-1:0]  ram_rd_data
);
  import fqs_pkg::*;

  state_t            state_r, state_nxt;
  req_t              req_r;
  logic [VAL_W-1:0]  val_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic [IDX_W-1:0]  front_r, front_nxt;
  logic              out_valid_r;
  res_t              out_res_r, res_nxt;
  logic              load_w, done_w, advance_w, accept_w, out_free_w;
  logic [CNT_W-1:0]  cnt_inc;

  assign out_free_w = !out_valid_r || out_ready;
  assign accept_w   = in_valid && in_ready;
  assign cnt_inc    = cnt_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept_w) state_nxt = S_EXEC;
      S_EXEC:  if (done_w) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state_r == S_IDLE);
    load_w      = 1'b0;
    done_w      = 1'b0;
    advance_w   = 1'b0;
    occ_nxt     = occ_r;
    front_nxt   = front_r;
    res_nxt     = '{status: ST_DONE, item: '0, pos: '0, last: 1'b1};
    ram_wr      = '{en: 1'b0, addr: slot_of(front_r, occ_r), data: val_r};
    if (state_r == S_EXEC) begin
      case (req_r)
        REQ_APPEND: begin
          if (out_free_w) begin
            load_w = 1'b1;
            done_w = 1'b1;
            if (occ_r >= CNT_W'(DEPTH)) begin
              res_nxt.status = ST_FULL;
            end else begin
              ram_wr.en = 1'b1;
              occ_nxt   = occ_r + 1'b1;
            end
          end
        end
        REQ_REMOVE: begin
          if (out_free_w) begin
            load_w = 1'b1;
            done_w = 1'b1;
            if (occ_r == '0) begin
              res_nxt.status = ST_EMPTY;
            end else begin
              res_nxt.item = ram_rd_data;
              front_nxt    = slot_of(front_r, CNT_W'(1));
              occ_nxt      = occ_r - 1'b1;
            end
          end
        end
        REQ_SEARCH: begin
          if (cnt_r == occ_r) begin
            res_nxt.status = ST_NOTFOUND;
            load_w = out_free_w;
            done_w = out_free_w;
          end else if (ram_rd_data == val_r) begin
            res_nxt.pos = POS_W'(cnt_inc);
            load_w = out_free_w;
            done_w = out_free_w;
          end else begin
            advance_w = 1'b1;
          end
        end
        default: begin
          if (out_free_w) begin
            load_w = 1'b1;
            if (occ_r == '0) begin
              res_nxt.status = ST_EMPTY;
              done_w = 1'b1;
            end else begin
              res_nxt.item = ram_rd_data;
              res_nxt.last = (cnt_inc == occ_r);
              done_w       = (cnt_inc == occ_r);
              advance_w    = (cnt_inc != occ_r);
            end
          end
        end
      endcase
    end
  end

  // Read one entry ahead: the address follows the offset of the next cycle.
  always_comb begin
    if (state_r == S_IDLE) begin
      cnt_nxt = '0;
    end else if (advance_w) begin
      cnt_nxt = cnt_inc;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  assign ram_rd_addr = slot_of(front_r, cnt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      front_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      front_r     <= front_nxt;
      if (load_w) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (accept_w) begin
      req_r <= in_req;
      val_r <= in_value;
    end
    if (load_w) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(DEPTH))
    else $error("occupancy beyond capacity");

  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_r < IDX_W'(DEPTH - 1) || front_r == IDX_W'(DEPTH - 1))
    else $error("front slot out of range");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    load_w && res_nxt.last |=> state_r == S_IDLE)
    else $error("final result did not end the request");

  a_mid_stays: assert property (@(posedge clk) disable iff (!rst_n)
    load_w && !res_nxt.last |=> state_r == S_EXEC && cnt_r == $past(cnt_inc))
    else $error("list did not advance after a non-final result");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr.en |=> occ_r == $past(occ_r) + 1'b1)
    else $error("append did not grow the queue");

endmodule

FILE: hw/rtl/fifo_queue_with_search.sv
// Top level of the searchable FIFO queue: stream ports, sequencer and entry RAM.
// Depends on fqs_pkg, fqs_ram and fqs_ctrl.
`timescale 1ns / 1ps

// Bounded FIFO of 16 signed 32-bit values with append, remove-front, search and
// list requests, selected by in_tuser. One request is worked on at a time;
// in_tready is high whenever no request is in progress, even while a result
// still waits in the output register. Append and remove are accepted, then
// executed. Search examines entries from the front until a match or the end of
// the queue. List gives one beat per cycle while the output is not stalled, one
// per entry, or a single empty-status beat on an empty queue. Output backpressure
// stalls a request whenever its result cannot be loaded; the entry RAM, with one
// write and one read port and read one entry per cycle, sets the scan speed. The
// entry RAM is not cleared after reset; only entries inside the occupancy ever
// reach a result.
module fifo_queue_with_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] item_value, [36:32] position, [39:37] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast
);
  import fqs_pkg::*;

  res_t              res;
  ram_wr_t           ram_wr;
  logic [IDX_W-1:0]  ram_rd_addr;
  logic [VAL_W-1:0]  ram_rd_data;

  fqs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_req      (req_t'(in_tuser)),
    .in_value    (in_tdata),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_res     (res),
    .ram_wr      (ram_wr),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  fqs_ram #(
    .WIDTH (VAL_W),
    .WORDS (DEPTH),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_tdata = {3'b000, res.pos, res.item};
  assign out_tuser = res.status;
  assign out_tlast = res.last;

endmodule

FILE: test/tb_fifo_queue_with_search.sv
// Testbench for fifo_queue_with_search: drives request beats, predicts every
// reply beat with its own queue model and checks the replies in order.
// Depends on fqs_pkg and the fifo_queue_with_search RTL.
`timescale 1ns / 1ps

module tb_fifo_queue_with_search;
  import fqs_pkg::*;

  localparam int RUN_LIMIT = 1_000_000;

  typedef struct {
    status_t     status;
    logic [31:0] item;
    logic [4:0]  pos;
    logic        last;
  } reply_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] value
  logic [1:0]  in_tuser;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [31:0] item_value, [36:32] position, [39:37] zero
  logic [1:0]  out_tuser;  // [1:0] status
  logic        out_tlast;

  // queue model
  logic signed [31:0] queue_slots [DEPTH];
  int                 queue_front;
  int                 queue_count;
  reply_t             due_replies [$];

  int mismatch_count;
  int cycle_count;
  bit idle_on;
  int stall_left;
  int hold_left;
  int hold_ask;

  fifo_queue_with_search dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void owe_reply(status_t status, logic [31:0] item,
                                    logic [4:0] pos, logic last);
    reply_t r;
    r.status = status;
    r.item   = item;
    r.pos    = pos;
    r.last   = last;
    due_replies.push_back(r);
  endfunction

  function automatic logic [31:0] queue_entry(int offset);
    return queue_slots[(queue_front + offset) % DEPTH];
  endfunction

  // Update the queue model for one accepted request and owe its replies.
  function automatic void model_queue_op(req_t req, logic [31:0] val);
    bit hit;
    hit = 1'b0;
    case (req)
      REQ_APPEND: begin
        if (queue_count >= DEPTH) begin
          owe_reply(ST_FULL, '0, '0, 1'b1);
        end else begin
          queue_slots[(queue_front + queue_count) % DEPTH] = val;
          queue_count++;
          owe_reply(ST_DONE, '0, '0, 1'b1);
        end
      end
      REQ_REMOVE: begin
        if (queue_count == 0) begin
          owe_reply(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          owe_reply(ST_DONE, queue_entry(0), '0, 1'b1);
          queue_front = (queue_front + 1) % DEPTH;
          queue_count--;
        end
      end
      REQ_SEARCH: begin
        for (int i = 0; i < queue_count; i++) begin
          if (!hit && queue_entry(i) == val) begin
            owe_reply(ST_DONE, '0, 5'(i + 1), 1'b1);
            hit = 1'b1;
          end
        end
        if (!hit) begin
          owe_reply(ST_NOTFOUND, '0, '0, 1'b1);
        end
      end
      default: begin
        if (queue_count == 0) begin
          owe_reply(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < queue_count; i++) begin
            owe_reply(ST_DONE, queue_entry(i), '0, i == queue_count - 1);
          end
        end
      end
    endcase
  endfunction

  function automatic void check_reply();
    reply_t want;
    if (due_replies.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("unexpected beat: status %0d item %h pos %0d last %0b",
                 out_tuser, out_tdata[31:0], out_tdata[36:32], out_tlast);
      end
    end else begin
      want = due_replies.pop_front();
      if (out_tuser != want.status || out_tdata[31:0] != want.item ||
          out_tdata[36:32] != want.pos || out_tlast != want.last) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("mismatch: expected status %0d item %h pos %0d last %0b",
                   want.status, want.item, want.pos, want.last);
          $display("          got      status %0d item %h pos %0d last %0b",
                   out_tuser, out_tdata[31:0], out_tdata[36:32], out_tlast);
        end
      end
    end
  endfunction

  // Reply side: check each beat, then stall at random or hold off on request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        check_reply();
        stall_left = idle_on ? $urandom_range(0, 15) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      if (hold_ask > 0) begin
        hold_left = hold_ask;
        hold_ask  = 0;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_tready <= (stall_left == 0) && (hold_left == 0);
    end
  end

  task automatic send_request(req_t req, logic [31:0] val);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
    model_queue_op(req, val);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4, 5:    return 32'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  // Weighted mix of requests; on a non-empty queue, half of the searches ask for a stored entry.
  task automatic run_mix(int count, int w_app, int w_rem, int w_srch, int w_list);
    int   roll;
    req_t req;
    logic [31:0] val;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, w_app + w_rem + w_srch + w_list - 1);
      val  = $urandom;
      if (roll < w_app) begin
        req = REQ_APPEND;
        val = pick_value();
      end else if (roll < w_app + w_rem) begin
        req = REQ_REMOVE;
      end else if (roll < w_app + w_rem + w_srch) begin
        req = REQ_SEARCH;
        if (queue_count > 0 && $urandom_range(0, 1) == 1) begin
          val = queue_entry($urandom_range(0, queue_count - 1));
        end else begin
          val = pick_value();
        end
      end else begin
        req = REQ_LIST;
      end
      send_request(req, val);
    end
  endtask

  task automatic test_empty_queue();
    idle_on = 1'b1;
    send_request(REQ_REMOVE, 32'h1234_5678);
    send_request(REQ_SEARCH, 32'h0000_0000);
    send_request(REQ_LIST, 32'hffff_ffff);
  endtask

  task automatic test_fill_to_capacity();
    logic [31:0] fill_vals [16] = '{
      32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
      32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 32'hffff_ffff,
      32'h1234_5678, 32'h0f0f_0f0f, 32'h0000_ffff, 32'hffff_0000,
      32'h0000_0002, 32'hffff_fffe, 32'h7fff_fffe, 32'h8000_0001
    };
    foreach (fill_vals[i]) begin
      send_request(REQ_APPEND, fill_vals[i]);
    end
    // drop on full
    send_request(REQ_APPEND, 32'h1357_9bdf);
    send_request(REQ_LIST, 32'h0);
    // duplicate value: first match wins
    send_request(REQ_SEARCH, 32'hffff_ffff);
    send_request(REQ_SEARCH, 32'h8000_0001);
    send_request(REQ_SEARCH, 32'h1357_9bdf);
    send_request(REQ_REMOVE, 32'h0);
  endtask

  task automatic test_backpressure();
    idle_on  = 1'b0;
    hold_ask = 400;
    run_mix(30, 3, 1, 1, 2);
  endtask

  task automatic test_random_traffic();
    idle_on = 1'b1;
    run_mix(90, 6, 2, 1, 1);
    idle_on = 1'b0;
    run_mix(60, 2, 5, 2, 1);
    idle_on = 1'b1;
    run_mix(90, 3, 3, 2, 2);
    run_mix(80, 5, 2, 2, 2);
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
    // catch stray beats after the last expected one
    repeat (40) @(posedge clk);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    queue_front    = 0;
    queue_count    = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    idle_on        = 1'b1;
    stall_left     = 0;
    hold_left      = 0;
    hold_ask       = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_fill_to_capacity();
    test_backpressure();
    test_random_traffic();
    drain_replies();

    if (mismatch_count == 0 && due_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/fqs_pkg.sv
hw/rtl/fqs_ram.sv
hw/rtl/fqs_ctrl.sv
hw/rtl/fifo_queue_with_search.sv
test/tb_fifo_queue_with_search.sv
